@@ rtl/red_pkg.sv @@
// red_pkg: shared constants and types for the rotary encoder debounce decoder
// no dependencies; used by red_out_if and imported by the core and the bench

package red_pkg;

	localparam int COUNT_BITS = 16;
	localparam int TIMER_BITS = 8;
	localparam int REG_W      = 8;
	localparam int REG_IDX_W  = 1;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [REG_W-1:0]      cfg_data_t;
	typedef logic [REG_IDX_W-1:0]  cfg_idx_t;
	typedef logic signed [COUNT_BITS-1:0] count_t;

	localparam cfg_idx_t REG_ROTARY_SETTLE = 1'd0;
	localparam cfg_idx_t REG_SWITCH_SETTLE = 1'd1;

	localparam cfg_data_t ROTARY_SETTLE_RST = 8'd3;
	localparam cfg_data_t SWITCH_SETTLE_RST = 8'd75;

	localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

endpackage

@@ rtl/red_in_if.sv @@
// red_in_if: sample channel, valid/ready handshake with pin levels and tick
// no package dependencies

interface red_in_if;
	logic valid;
	logic ready;
	logic pin_a;
	logic pin_b;
	logic pin_sw;
	logic ms_tick;

	modport source (output valid, pin_a, pin_b, pin_sw, ms_tick, input ready);
	modport sink   (input valid, pin_a, pin_b, pin_sw, ms_tick, output ready);
endinterface

@@ rtl/red_out_if.sv @@
// red_out_if: result channel, valid/ready handshake with step, press and position
// depends on red_pkg for the position width

interface red_out_if;
	logic valid;
	logic ready;
	logic step_up;
	logic step_down;
	logic press_pulse;
	logic signed [red_pkg::COUNT_BITS-1:0] position;
	logic led_level;

	modport source (output valid, step_up, step_down, press_pulse, position, led_level,
		input ready);
	modport sink   (input valid, step_up, step_down, press_pulse, position, led_level,
		output ready);
endinterface

@@ rtl/rotary_encoder_debounce_decoder_core.sv @@
// rotary_encoder_debounce_decoder_core: debounced quadrature decoder with push switch
// depends on red_pkg, red_in_if, red_out_if
//
//   channel  | dir | handshake        | payload
//   sample   | in  | valid/ready      | pin_a, pin_b, pin_sw, ms_tick
//   result   | out | valid/ready      | step_up, step_down, press_pulse, position, led_level
//   cfg      | in  | cfg_we only      | cfg_index, cfg_data
//
// one sample per cycle while sample ready is high; each result is registered on its transfer
// decoder state updates in the same edge as the sample transfer
// sample ready stays high while the output register is empty or being taken
// reset: timers idle, position zero, led off, settle times 3 ms and 75 ms

module rotary_encoder_debounce_decoder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  red_pkg::cfg_idx_t    cfg_index,
	input  red_pkg::cfg_data_t   cfg_data,
	red_in_if.sink               sample,
	red_out_if.source            result
);
	import red_pkg::*;

	cfg_data_t rot_settle_q, sw_settle_q;
	logic      last_a_q, last_sw_q;
	logic      rbusy_q, sbusy_q;
	timer_t    rel_q, sel_q;
	count_t    detent_q;
	logic      led_q;
	logic      out_valid_q;
	logic      up_q, down_q, press_q;

	logic      acc;
	logic      rbusy_n, sbusy_n, rbusy_f, sbusy_f;
	timer_t    rel_n, sel_n;
	logic      r_fire, skip_sw, s_fire;
	logic      up_n, down_n, press_n;
	count_t    detent_n;
	logic      led_n;

	assign sample.ready = !out_valid_q || result.ready;
	assign acc          = sample.valid && sample.ready;

	always_comb begin
		rel_n = rel_q;
		sel_n = sel_q;
		if (sample.ms_tick && rbusy_q && rel_q != TIMER_MAX) begin
			rel_n = rel_q + 1'b1;
		end
		if (sample.ms_tick && sbusy_q && sel_q != TIMER_MAX) begin
			sel_n = sel_q + 1'b1;
		end
		rbusy_n = rbusy_q;
		sbusy_n = sbusy_q;
		if (last_a_q && !sample.pin_a && !rbusy_q) begin
			rbusy_n = 1'b1;
			rel_n   = '0;
		end
		if ((sample.pin_sw != last_sw_q) && !sbusy_q) begin
			sbusy_n = 1'b1;
			sel_n   = '0;
		end
		r_fire   = rbusy_n && (rel_n >= rot_settle_q);
		skip_sw  = r_fire && sample.pin_a;
		up_n     = r_fire && !sample.pin_a && !sample.pin_b;
		down_n   = r_fire && !sample.pin_a && sample.pin_b;
		rbusy_f  = rbusy_n && !r_fire;
		s_fire   = !skip_sw && sbusy_n && (sel_n >= sw_settle_q) && !sample.pin_sw;
		press_n  = s_fire;
		sbusy_f  = sbusy_n && !s_fire;
		detent_n = detent_q;
		if (up_n) begin
			detent_n = detent_q + 1'b1;
		end else if (down_n) begin
			detent_n = detent_q - 1'b1;
		end
		led_n = led_q ^ s_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_settle_q <= ROTARY_SETTLE_RST;
			sw_settle_q  <= SWITCH_SETTLE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROTARY_SETTLE: rot_settle_q <= cfg_data;
				REG_SWITCH_SETTLE: sw_settle_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q  <= 1'b1;
			last_sw_q <= 1'b1;
			rbusy_q   <= 1'b0;
			sbusy_q   <= 1'b0;
			rel_q     <= '0;
			sel_q     <= '0;
			detent_q  <= '0;
			led_q     <= 1'b0;
		end else if (acc) begin
			last_a_q  <= sample.pin_a;
			last_sw_q <= sample.pin_sw;
			rbusy_q   <= rbusy_f;
			sbusy_q   <= sbusy_f;
			rel_q     <= rel_n;
			sel_q     <= sel_n;
			detent_q  <= detent_n;
			led_q     <= led_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			up_q    <= up_n;
			down_q  <= down_n;
			press_q <= press_n;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.step_up     = up_q;
	assign result.step_down   = down_q;
	assign result.press_pulse = press_q;
	assign result.position    = detent_q;
	assign result.led_level   = led_q;

	a_up_down_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(up_n && down_n))
		else $error("step up and step down together");

	a_up_incr: assert property (@(posedge clk) disable iff (!arst_n)
		acc && up_n |=> detent_q == count_t'($past(detent_q) + 1'b1))
		else $error("increment not applied");

	a_press_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		acc && press_n |=> led_q != $past(led_q))
		else $error("led not toggled on press");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(detent_q) && $stable(led_q) && $stable(rbusy_q))
		else $error("state changed without transfer");

	a_skip_press: assert property (@(posedge clk) disable iff (!arst_n)
		press_n |-> !(r_fire && sample.pin_a))
		else $error("press on skipped sample");

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking bench for rotary_encoder_debounce_decoder_core
// depends on red_pkg, red_in_if, red_out_if and the core; predicts every result
// from pin samples and register writes, then checks the result channel in order

module tb_top;
	import red_pkg::*;

	typedef struct packed {
		logic a;
		logic b;
		logic sw;
		logic tick;
	} pin_sample_t;

	typedef struct packed {
		logic   step_up;
		logic   step_down;
		logic   press_pulse;
		count_t position;
		logic   led_level;
	} decode_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cfg_we    = 1'b0;
	cfg_idx_t  cfg_index = REG_ROTARY_SETTLE;
	cfg_data_t cfg_data  = '0;

	logic tx_valid = 1'b0;
	logic tx_a     = 1'b1;
	logic tx_b     = 1'b1;
	logic tx_sw    = 1'b1;
	logic tx_tick  = 1'b0;
	logic rx_ready = 1'b0;

	red_in_if  sample_ch ();
	red_out_if result_ch ();

	assign sample_ch.valid   = tx_valid;
	assign sample_ch.pin_a   = tx_a;
	assign sample_ch.pin_b   = tx_b;
	assign sample_ch.pin_sw  = tx_sw;
	assign sample_ch.ms_tick = tx_tick;
	assign result_ch.ready   = rx_ready;

	rotary_encoder_debounce_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always #6 clk = ~clk;

	pin_sample_t pending_samples[$];
	decode_t     expected_decodes[$];

	// decoder state as predicted
	cfg_data_t rot_limit  = ROTARY_SETTLE_RST;
	cfg_data_t sw_limit   = SWITCH_SETTLE_RST;
	logic      a_prev     = 1'b1;
	logic      sw_prev    = 1'b1;
	logic      rot_running = 1'b0;
	timer_t    rot_ms     = '0;
	logic      sw_running = 1'b0;
	timer_t    sw_ms      = '0;
	count_t    detent     = '0;
	logic      led        = 1'b0;

	logic gen_a  = 1'b1;
	logic gen_b  = 1'b1;
	logic gen_sw = 1'b1;
	int   gen_count = 0;

	logic calm        = 1'b0;
	int   stall_left  = 0;
	logic stall_done  = 1'b0;
	int   decodes_seen = 0;
	int   samples_sent = 0;
	int   error_count  = 0;
	int   ups_seen     = 0;
	int   downs_seen   = 0;
	int   presses_seen = 0;

	function automatic decode_t decode_sample(pin_sample_t s);
		decode_t r;
		logic    skip_sw;
		r = '0;
		skip_sw = 1'b0;
		if (s.tick) begin
			if (rot_running && rot_ms != TIMER_MAX)
				rot_ms = rot_ms + 1'b1;
			if (sw_running && sw_ms != TIMER_MAX)
				sw_ms = sw_ms + 1'b1;
		end
		if (a_prev && !s.a && !rot_running) begin
			rot_running = 1'b1;
			rot_ms = '0;
		end
		if (s.sw != sw_prev && !sw_running) begin
			sw_running = 1'b1;
			sw_ms = '0;
		end
		a_prev = s.a;
		sw_prev = s.sw;
		if (rot_running && rot_ms >= rot_limit) begin
			rot_running = 1'b0;
			if (s.a) begin
				skip_sw = 1'b1;
			end else if (s.a == s.b) begin
				r.step_up = 1'b1;
				detent = detent + 1'b1;
			end else begin
				r.step_down = 1'b1;
				detent = detent - 1'b1;
			end
		end
		if (!skip_sw && sw_running && sw_ms >= sw_limit && !s.sw) begin
			sw_running = 1'b0;
			r.press_pulse = 1'b1;
			led = ~led;
		end
		r.position = detent;
		r.led_level = led;
		return r;
	endfunction

	// sample driver
	always @(posedge clk) begin : drive_samples
		pin_sample_t s;
		if (tx_valid && sample_ch.ready) begin
			s = '{a: tx_a, b: tx_b, sw: tx_sw, tick: tx_tick};
			expected_decodes.push_back(decode_sample(s));
			samples_sent++;
		end
		if (!tx_valid || sample_ch.ready) begin
			if (arst_n && pending_samples.size() != 0 &&
				(calm || $urandom_range(0, 99) >= 19)) begin
				s = pending_samples.pop_front();
				tx_valid <= 1'b1;
				tx_a <= s.a;
				tx_b <= s.b;
				tx_sw <= s.sw;
				tx_tick <= s.tick;
			end else begin
				tx_valid <= 1'b0;
			end
		end
	end

	// long hold on the result side once the run is under way
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_done && decodes_seen >= 500) begin
			stall_left <= 250;
			stall_done <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin : check_decodes
		decode_t got;
		decode_t want;
		if (result_ch.valid && rx_ready) begin
			got.step_up = result_ch.step_up;
			got.step_down = result_ch.step_down;
			got.press_pulse = result_ch.press_pulse;
			got.position = result_ch.position;
			got.led_level = result_ch.led_level;
			decodes_seen <= decodes_seen + 1;
			ups_seen += got.step_up;
			downs_seen += got.step_down;
			presses_seen += got.press_pulse;
			if (expected_decodes.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result transfer at %0t", $realtime);
			end else begin
				want = expected_decodes.pop_front();
				if (got !== want) begin
					error_count++;
					if (error_count <= 10) begin
						$display("mismatch at %0t: want up=%0d dn=%0d pr=%0d pos=%0d led=%0d",
							$realtime, want.step_up, want.step_down, want.press_pulse,
							want.position, want.led_level);
						$display("  got up=%0d dn=%0d pr=%0d pos=%0d led=%0d",
							got.step_up, got.step_down, got.press_pulse, got.position,
							got.led_level);
					end
				end
			end
		end
		rx_ready <= arst_n && stall_left == 0 && (calm || $urandom_range(0, 99) >= 19);
	end

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic add_sample(logic a, logic b, logic sw, logic tick);
		pending_samples.push_back('{a: a, b: b, sw: sw, tick: tick});
		gen_a = a;
		gen_b = b;
		gen_sw = sw;
		gen_count++;
	endtask

	task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ROTARY_SETTLE: rot_limit = val;
			REG_SWITCH_SETTLE: sw_limit = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || tx_valid || expected_decodes.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	// hold a level for a settle time counted in ticks, with a few tickless samples
	task automatic hold_ticks(logic a, logic b, logic sw, int settle);
		int   left;
		logic t;
		left = settle + $urandom_range(0, 2);
		while (left > 0) begin
			t = ($urandom_range(0, 4) != 0);
			add_sample(a, b, sw, t);
			if (t)
				left--;
		end
	endtask

	task automatic gen_turn(logic up_dir, logic broken);
		logic b;
		b = ~up_dir;
		if (!gen_a)
			add_sample(1'b1, coin(), gen_sw, coin());
		add_sample(1'b0, b, gen_sw, coin());
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) begin
				add_sample(1'b1, b, gen_sw, 1'b0);
				add_sample(1'b0, b, gen_sw, 1'b0);
			end
		if (broken)
			add_sample(1'b1, coin(), gen_sw, coin());
		else
			hold_ticks(1'b0, b, gen_sw, int'(rot_limit));
		add_sample(1'b1, coin(), gen_sw, coin());
	endtask

	task automatic gen_press();
		if (!gen_sw)
			add_sample(gen_a, gen_b, 1'b1, coin());
		add_sample(gen_a, gen_b, 1'b0, coin());
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) begin
				add_sample(gen_a, gen_b, 1'b1, 1'b0);
				add_sample(gen_a, gen_b, 1'b0, 1'b0);
			end
		hold_ticks(gen_a, gen_b, 1'b0, int'(sw_limit));
		repeat ($urandom_range(1, 4))
			add_sample(gen_a, gen_b, 1'b1, coin());
	endtask

	task automatic run_phase(cfg_data_t rot, cfg_data_t sw, int n, logic quiet);
		int start;
		int pick;
		write_reg(REG_ROTARY_SETTLE, rot);
		write_reg(REG_SWITCH_SETTLE, sw);
		calm = quiet;
		start = gen_count;
		while (gen_count - start < n) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3)
				gen_turn(coin(), 1'b0);
			else if (pick <= 6)
				gen_press();
			else if (pick <= 8)
				repeat ($urandom_range(1, 6))
					add_sample(coin(), coin(), coin(), coin());
			else
				gen_turn(coin(), 1'b1);
		end
		drain();
		calm = 1'b0;
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: up, then A high at expiry with the switch check skipped
		add_sample(1'b1, 1'b1, 1'b1, 1'b0);
		add_sample(1'b1, 1'b1, 1'b1, 1'b1);
		add_sample(1'b0, 1'b0, 1'b1, 1'b0);
		repeat (3) add_sample(1'b0, 1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1, 1'b0);
		repeat (3) add_sample(1'b0, 1'b1, 1'b1, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1, 1'b0);
		add_sample(1'b0, 1'b0, 1'b1, 1'b0);
		add_sample(1'b1, 1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b0, 1'b0, 1'b1);
		add_sample(1'b1, 1'b1, 1'b0, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1, 1'b0);
		drain();

		// zero settle: expiry on the starting sample
		write_reg(REG_ROTARY_SETTLE, 8'd0);
		write_reg(REG_SWITCH_SETTLE, 8'd0);
		add_sample(1'b0, 1'b0, 1'b1, 1'b0);
		add_sample(1'b1, 1'b1, 1'b0, 1'b0);
		add_sample(1'b0, 1'b1, 1'b1, 1'b0);
		add_sample(1'b1, 1'b1, 1'b0, 1'b0);
		add_sample(1'b0, 1'b0, 1'b0, 1'b1);
		add_sample(1'b1, 1'b1, 1'b1, 1'b1);
		drain();

		run_phase(8'd1, 8'd1, 300, 1'b0);
		run_phase(8'd3, 8'd5, 300, 1'b0);
		run_phase(8'd2, 8'd9, 300, 1'b1);
		run_phase(8'd255, 8'd2, 300, 1'b0);
		run_phase(8'd1, 8'd255, 300, 1'b0);
		run_phase(ROTARY_SETTLE_RST, SWITCH_SETTLE_RST, 200, 1'b0);

		$display("%0d samples, %0d results: %0d up, %0d down, %0d presses",
			samples_sent, decodes_seen, ups_seen, downs_seen, presses_seen);
		$display("settle times 0 to 255, bounces, broken turns, a long result stall");
		if (error_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin : watchdog
		#(12 * 3000000);
		$display("tb_top failed");
		$finish;
	end

endmodule
